// File: hw/rtl/assert_macros.svh
// Assertion helper macros shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that an implication holds at every clock edge outside reset.
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check an implication that must hold during reset as well.
`define ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// File: hw/rtl/stt_pkg.sv
// ----------------------------------------------------------------------------
// stt_pkg
// Shared types, kind codes and character class helpers for the tokenizer.
// ----------------------------------------------------------------------------
package stt_pkg;

  localparam int KeywordChars = 8;
  localparam int KwIdxW = $clog2(KeywordChars);
  localparam logic [19:0] LineMax = 20'hFFFFF;
  localparam logic [15:0] U16Max = 16'hFFFF;

  // Record queue depth, a power of two so the pointers wrap on their own.
  localparam int QueueDepth = 8;
  localparam int QPtrW = $clog2(QueueDepth);

  localparam logic [5:0] KIND_IDENT = 6'd0;
  localparam logic [5:0] KIND_NUMBER = 6'd1;
  localparam logic [5:0] KIND_STRING = 6'd2;
  localparam logic [5:0] KIND_LINE_CMT = 6'd3;
  localparam logic [5:0] KIND_BLOCK_CMT = 6'd4;
  localparam logic [5:0] KIND_EQEQ = 6'd9;
  localparam logic [5:0] KIND_NEQ = 6'd13;

  typedef enum logic [2:0] {
    MODE_IDLE   = 3'd0,
    MODE_IDENT  = 3'd1,
    MODE_NUMBER = 3'd2,
    MODE_STRING = 3'd3,
    MODE_LINE   = 3'd4,
    MODE_BLOCK  = 3'd5,
    MODE_STAR   = 3'd6
  } lex_mode_t;

  // One token record as it travels to the output queue.
  typedef struct packed {
    logic [5:0]  token_kind;
    logic        is_error;
    logic [19:0] line_number;
    logic [15:0] column_number;
    logic [15:0] token_length;
    logic [7:0]  bad_byte;
    logic        run_last;
  } token_rec_t;

  function automatic logic [5:0] punct_kind(input logic [7:0] c);
    logic [5:0] k;
    k = 6'd0;
    case (c)
      8'h7B: k = 6'd5;   8'h7D: k = 6'd6;   8'h3A: k = 6'd7;
      8'h3D: k = 6'd8;   8'h3E: k = 6'd10;  8'h3C: k = 6'd11;
      8'h21: k = 6'd12;  8'h2B: k = 6'd14;  8'h40: k = 6'd15;
      8'h2D: k = 6'd16;  8'h2F: k = 6'd17;  8'h2A: k = 6'd18;
      8'h3B: k = 6'd19;  8'h28: k = 6'd20;  8'h29: k = 6'd21;
      8'h5B: k = 6'd22;  8'h5D: k = 6'd23;  8'h2C: k = 6'd24;
      8'h2E: k = 6'd25;
      default: k = 6'd0;
    endcase
    return k;
  endfunction

  function automatic logic is_alpha(input logic [7:0] c);
    return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A);
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return c >= 8'h30 && c <= 8'h39;
  endfunction

  function automatic logic [15:0] sat_inc16(input logic [15:0] v);
    return (v == U16Max) ? v : v + 16'd1;
  endfunction

  // Keyword lookup on the stored word prefix and the run length.
  function automatic logic [5:0] kw_kind(input logic [KeywordChars*8-1:0] w,
                                         input logic [15:0] len);
    logic [5:0] k;
    logic [63:0] s;
    k = KIND_IDENT;
    s = w[63:0];
    // s holds byte 0 in bits [7:0]
    case (len)
      16'd2: begin
        if (s[15:0] == {"n","f"}) k = 6'd28;
        else if (s[15:0] == {"p","o"}) k = 6'd30;
        else if (s[15:0] == {"n","i"}) k = 6'd31;
        else if (s[15:0] == {"f","i"}) k = 6'd32;
      end
      16'd3: begin
        if (s[23:0] == {"c","e","d"}) k = 6'd29;
        else if (s[23:0] == {"t","e","s"}) k = 6'd39;
        else if (s[23:0] == {"t","e","g"}) k = 6'd43;
      end
      16'd4: begin
        if (s[31:0] == {"e","u","r","t"}) k = 6'd27;
        else if (s[31:0] == {"l","p","m","i"}) k = 6'd33;
        else if (s[31:0] == {"p","o","o","l"}) k = 6'd34;
        else if (s[31:0] == {"e","s","l","e"}) k = 6'd42;
      end
      16'd5: begin
        if (s[39:0] == {"e","s","l","a","f"}) k = 6'd27;
        else if (s[39:0] == {"k","a","e","r","b"}) k = 6'd41;
      end
      16'd6: begin
        if (s[47:0] == {"n","r","u","t","e","r"}) k = 6'd36;
        else if (s[47:0] == {"x","i","f","e","r","p"}) k = 6'd37;
        else if (s[47:0] == {"t","c","u","r","t","s"}) k = 6'd38;
        else if (s[47:0] == {"x","i","f","f","u","s"}) k = 6'd40;
      end
      16'd8: begin
        if (s == {"e","u","n","i","t","n","o","c"}) k = 6'd35;
      end
      default: k = KIND_IDENT;
    endcase
    return k;
  endfunction

endpackage

// File: hw/rtl/source_text_tokenizer_top.sv
// One byte in per cycle while in_ready, one record out per cycle while out_ready.
// The record queue (8 deep) holds input off only when a burst of records backs up.
// Reset: synchronous active-low rst_n returns scanner and queue to the start of text.
// ----------------------------------------------------------------------------
// source_text_tokenizer_top
// Streaming tokenizer: scanner front end feeding a record queue.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"
module source_text_tokenizer_top import stt_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_text_byte,
  input  logic        in_end_of_text,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [5:0]  out_token_kind,
  output logic        out_is_error,
  output logic [19:0] out_line_number,
  output logic [15:0] out_column_number,
  output logic [15:0] out_token_length,
  output logic [7:0]  out_bad_byte,
  output logic        out_run_last
);

  token_rec_t [2:0] recs;
  logic [1:0] rec_cnt, wr_cnt;
  logic room, step;
  token_rec_t head;

  // Accept a transaction whenever the queue can take a worst-case burst.
  assign in_ready = room;
  assign step = in_valid && in_ready;
  assign wr_cnt = step ? rec_cnt : 2'd0;

  stt_front u_front (
    .clk, .rst_n, .step,
    .text_byte(in_text_byte), .end_of_text(in_end_of_text),
    .recs, .rec_cnt
  );

  stt_queue u_queue (
    .clk, .rst_n, .wr_recs(recs), .wr_cnt, .has_room(room),
    .rd_rec(head), .rd_valid(out_valid), .rd_pop(out_ready)
  );

  assign out_token_kind = head.token_kind;
  assign out_is_error = head.is_error;
  assign out_line_number = head.line_number;
  assign out_column_number = head.column_number;
  assign out_token_length = head.token_length;
  assign out_bad_byte = head.bad_byte;
  assign out_run_last = head.run_last;

  `ASSERT_CLK(a_err_len, clk, rst_n, out_valid && out_is_error |-> out_token_length == 16'd1, "error record length")
  `ASSERT_CLK(a_line_nz, clk, rst_n, out_valid |-> out_line_number != 20'd0, "line zero")
  `ASSERT_CLK(a_room, clk, rst_n, !in_ready |-> out_valid, "stalled with empty queue")

endmodule

// File: hw/rtl/stt_front.sv
// ----------------------------------------------------------------------------
// stt_front
// Scanner: takes one byte per cycle when step is high and forms up to two token records.
// ----------------------------------------------------------------------------
module stt_front import stt_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             step,
  input  logic [7:0]       text_byte,
  input  logic             end_of_text,
  output token_rec_t [2:0] recs,
  output logic [1:0]       rec_cnt
);

  lex_mode_t mode_r, mode_nxt;
  logic [7:0] held_r, held_nxt, prev_r, prev_nxt;
  logic held_v_r, held_v_nxt;
  logic [KeywordChars*8-1:0] word_r, word_nxt;
  logic [19:0] sline_r, sline_nxt, cline_r, cline_nxt;
  logic [15:0] scol_r, scol_nxt, ccol_r, ccol_nxt, run_r, run_nxt;

  always_comb begin
    logic [7:0] c;
    logic [19:0] cl;
    logic [15:0] cc;
    logic consumed, last, scan;
    logic [5:0] pk;
    c = text_byte;
    last = end_of_text;
    pk = 6'd0;
    mode_nxt = mode_r; held_nxt = held_r; held_v_nxt = held_v_r; prev_nxt = prev_r;
    word_nxt = word_r; sline_nxt = sline_r; scol_nxt = scol_r; run_nxt = run_r;
    recs = '0; rec_cnt = 2'd0; consumed = 1'b0; scan = 1'b0;
    if (c == 8'h0A) begin
      cline_nxt = (cline_r < LineMax) ? cline_r + 20'd1 : cline_r;
      cc = 16'd0;
    end else begin
      cline_nxt = cline_r;
      cc = ccol_r;
    end
    cl = cline_nxt;
    ccol_nxt = sat_inc16(cc);

    if (held_v_r) begin
      held_v_nxt = 1'b0;
      if (held_r == 8'h2F && c == 8'h2F) begin
        mode_nxt = MODE_LINE; run_nxt = 16'd2; consumed = 1'b1;
      end else if (held_r == 8'h2F && c == 8'h2A) begin
        mode_nxt = MODE_BLOCK; run_nxt = 16'd2; consumed = 1'b1;
      end else if (held_r == 8'h3D && c == 8'h3D) begin
        recs[rec_cnt] = '{KIND_EQEQ, 1'b0, sline_r, scol_r, 16'd2, 8'd0, 1'b0};
        rec_cnt = rec_cnt + 2'd1; consumed = 1'b1;
      end else if (held_r == 8'h21 && c == 8'h3D) begin
        recs[rec_cnt] = '{KIND_NEQ, 1'b0, sline_r, scol_r, 16'd2, 8'd0, 1'b0};
        rec_cnt = rec_cnt + 2'd1; consumed = 1'b1;
      end else begin
        recs[rec_cnt] = '{punct_kind(held_r), 1'b0, sline_r, scol_r, 16'd1, 8'd0, 1'b0};
        rec_cnt = rec_cnt + 2'd1;
      end
    end

    if (!consumed) begin
      case (mode_r)
        MODE_LINE: begin
          if (c == 8'h0A) begin
            recs[rec_cnt] = '{KIND_LINE_CMT, 1'b0, sline_r, scol_r, run_r, 8'd0, 1'b0};
            rec_cnt = rec_cnt + 2'd1; mode_nxt = MODE_IDLE;
          end else run_nxt = sat_inc16(run_r);
        end
        MODE_BLOCK: begin
          run_nxt = sat_inc16(run_r);
          if (c == 8'h2A) mode_nxt = MODE_STAR;
        end
        MODE_STAR: begin
          run_nxt = sat_inc16(run_r);
          if (c == 8'h2F) begin
            recs[rec_cnt] = '{KIND_BLOCK_CMT, 1'b0, sline_r, scol_r, run_nxt, 8'd0, 1'b0};
            rec_cnt = rec_cnt + 2'd1; mode_nxt = MODE_IDLE;
          end else if (c != 8'h2A) mode_nxt = MODE_BLOCK;
        end
        MODE_STRING: begin
          run_nxt = sat_inc16(run_r);
          if (c == 8'h22 && prev_r != 8'h5C) begin
            recs[rec_cnt] = '{KIND_STRING, 1'b0, sline_r, scol_r, run_nxt, 8'd0, 1'b0};
            rec_cnt = rec_cnt + 2'd1; mode_nxt = MODE_IDLE;
          end
        end
        MODE_IDENT: begin
          if (is_alpha(c) || is_digit(c) || c == 8'h5F) begin
            if (run_r < 16'(KeywordChars)) word_nxt[run_r[KwIdxW-1:0]*8 +: 8] = c;
            run_nxt = sat_inc16(run_r);
          end else begin
            recs[rec_cnt] = '{kw_kind(word_r, run_r), 1'b0, sline_r, scol_r, run_r,
                              8'd0, 1'b0};
            rec_cnt = rec_cnt + 2'd1; scan = 1'b1;
          end
        end
        MODE_NUMBER: begin
          if (is_digit(c) || c == 8'h66 || c == 8'h69 || c == 8'h75 || c == 8'h2E ||
              c == 8'h5F) run_nxt = sat_inc16(run_r);
          else begin
            recs[rec_cnt] = '{KIND_NUMBER, 1'b0, sline_r, scol_r, run_r, 8'd0, 1'b0};
            rec_cnt = rec_cnt + 2'd1; scan = 1'b1;
          end
        end
        default: scan = 1'b1;
      endcase
    end

    if (scan) begin
      pk = punct_kind(c);
      mode_nxt = MODE_IDLE;
      if (c == 8'h2F || c == 8'h3D || c == 8'h21) begin
        if (last) begin
          recs[rec_cnt] = '{pk, 1'b0, cl, cc, 16'd1, 8'd0, 1'b0};
          rec_cnt = rec_cnt + 2'd1;
        end else begin
          held_nxt = c; held_v_nxt = 1'b1; sline_nxt = cl; scol_nxt = cc;
        end
      end else if (c == 8'h22) begin
        mode_nxt = MODE_STRING; run_nxt = 16'd1; sline_nxt = cl; scol_nxt = cc;
      end else if (pk != 6'd0) begin
        recs[rec_cnt] = '{pk, 1'b0, cl, cc, 16'd1, 8'd0, 1'b0};
        rec_cnt = rec_cnt + 2'd1;
      end else if (is_digit(c)) begin
        mode_nxt = MODE_NUMBER; run_nxt = 16'd1; sline_nxt = cl; scol_nxt = cc;
      end else if (is_alpha(c) || c == 8'h5F) begin
        mode_nxt = MODE_IDENT; word_nxt[7:0] = c; run_nxt = 16'd1;
        sline_nxt = cl; scol_nxt = cc;
      end else if (c != 8'h20 && c != 8'h09 && c != 8'h0A) begin
        recs[rec_cnt] = '{KIND_IDENT, 1'b1, cl, cc, 16'd1, c, 1'b0};
        rec_cnt = rec_cnt + 2'd1;
      end
    end

    if (last) begin
      if (mode_nxt == MODE_IDENT) begin
        recs[rec_cnt] = '{kw_kind(word_nxt, run_nxt), 1'b0, sline_nxt, scol_nxt, run_nxt,
                          8'd0, 1'b0};
        rec_cnt = rec_cnt + 2'd1;
      end else if (mode_nxt == MODE_NUMBER) begin
        recs[rec_cnt] = '{KIND_NUMBER, 1'b0, sline_nxt, scol_nxt, run_nxt, 8'd0, 1'b0};
        rec_cnt = rec_cnt + 2'd1;
      end
      mode_nxt = MODE_IDLE; held_nxt = 8'd0; held_v_nxt = 1'b0; prev_nxt = 8'h20;
      sline_nxt = 20'd1; scol_nxt = 16'd0; run_nxt = 16'd0;
      cline_nxt = 20'd1; ccol_nxt = 16'd0;
    end else prev_nxt = c;

    if (rec_cnt != 2'd0) recs[rec_cnt - 2'd1].run_last = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_IDLE; held_r <= 8'd0; held_v_r <= 1'b0; prev_r <= 8'h20;
      sline_r <= 20'd1; scol_r <= 16'd0; run_r <= 16'd0;
      cline_r <= 20'd1; ccol_r <= 16'd0;
    end else if (step) begin
      mode_r <= mode_nxt; held_r <= held_nxt; held_v_r <= held_v_nxt;
      prev_r <= prev_nxt; sline_r <= sline_nxt; scol_r <= scol_nxt;
      run_r <= run_nxt; cline_r <= cline_nxt; ccol_r <= ccol_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (step) word_r <= word_nxt;
  end

endmodule

// File: hw/rtl/stt_queue.sv
// ----------------------------------------------------------------------------
// stt_queue
// Record queue: writes up to three records a cycle, pops one.
// ----------------------------------------------------------------------------
module stt_queue import stt_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  token_rec_t [2:0] wr_recs,
  input  logic [1:0]       wr_cnt,
  output logic             has_room,
  output token_rec_t       rd_rec,
  output logic             rd_valid,
  input  logic             rd_pop
);

  token_rec_t mem_r [QueueDepth];
  logic [QPtrW-1:0] wp_r, rp_r;
  logic [QPtrW:0] cnt_r;
  logic pop;

  assign rd_valid = cnt_r != '0;
  assign rd_rec = mem_r[rp_r];
  assign pop = rd_pop && rd_valid;
  // Leave space for a full three-record burst.
  assign has_room = cnt_r <= (QPtrW+1)'(QueueDepth - 3);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= '0; rp_r <= '0; cnt_r <= '0;
    end else begin
      wp_r <= wp_r + QPtrW'(wr_cnt);
      rp_r <= rp_r + QPtrW'(pop);
      cnt_r <= cnt_r + (QPtrW+1)'(wr_cnt) - (QPtrW+1)'(pop);
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      if (2'(i) < wr_cnt) mem_r[wp_r + QPtrW'(i)] <= wr_recs[i];
    end
  end

endmodule
